@@ sv/irbfs_pkg.sv @@
// Package with the types and codes shared by the IR beacon frame sequencer files.
`timescale 1ns / 1ps

package irbfs_pkg;

  // Widths fixed by the register map and the item fields.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int ID_W       = 8;
  localparam int LEN_W      = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BEACON_ID        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_ON_LEN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_GAP_LEN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BIT_LEN     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPILOGUE_ON_LEN  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EPILOGUE_GAP_LEN = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP_LEN     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_DIRECT   = 4'd7;

  // Request kinds.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Frame phases.
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PH_W-1:0] PH_PRE  = 3'd1;
  localparam logic [PH_W-1:0] PH_DATA = 3'd2;
  localparam logic [PH_W-1:0] PH_EGAP = 3'd3;
  localparam logic [PH_W-1:0] PH_EON  = 3'd4;
  localparam logic [PH_W-1:0] PH_END  = 3'd5;

  // Word selector codes.
  localparam logic [1:0] WORD_ID    = 2'd0;
  localparam logic [1:0] WORD_ANGLE = 2'd1;
  localparam logic [1:0] WORD_COMPL = 2'd2;

  typedef struct packed {
    logic            req_type;
    logic [ID_W-1:0] angle_word;
  } in_item_t;

  typedef struct packed {
    logic             carrier_on;
    logic [LEN_W-1:0] period_length;
    logic             start_taken;
    logic             start_refused;
    logic             frame_done;
    logic             busy_res;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_req_t;

endpackage

@@ sv/irbfs_stream_if.sv @@
// Valid/ready channel interface used for the request, result and configuration channels.
`timescale 1ns / 1ps

interface irbfs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ir_beacon_frame_sequencer_top.sv @@
// Top level of the IR beacon frame sequencer: frame state machine and result register.
`timescale 1ns / 1ps

// The block sends one infrared beacon frame per start request. Each tick
// request (req_type 0) yields the carrier level, after polarity, and the
// length of the period that begins now; a start request (req_type 1) latches
// the angle code and begins a frame when idle, or is refused and flagged when
// a frame is in progress. A frame is a preamble of on, off, on, off, then the
// beacon id, the angle code and its complement, WORD_BITS bits each MSB first,
// then an epilogue of off and on; the following tick returns to idle with the
// interframe length and raises frame_done. Every request gives exactly one
// result. Throughput is one request per clock cycle while out_if.ready is
// high, and the result appears in the cycle after the request is taken: the
// state update is a single pass of logic into the state and result
// registers, and the result register lets a new request in while its output
// waits, as long as out_if.ready is high on that cycle. Configuration writes
// are always taken and should be made only while no result is outstanding.
module ir_beacon_frame_sequencer_top #(
  parameter int WORD_BITS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  irbfs_stream_if.sink   in_if,
  irbfs_stream_if.source out_if,
  irbfs_stream_if.sink   cfg_if
);

  // Bit counter must hold the preamble steps (0..3), WORD_BITS-1, and give
  // three bits for selecting a bit of an 8-bit word.
  localparam int CLOG_WB = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int IDX_W   = (CLOG_WB > 3) ? CLOG_WB : 3;
  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(WORD_BITS - 1);
  localparam logic [irbfs_pkg::LEN_W-1:0] PER_MASK =
    (PERIOD_BITS >= irbfs_pkg::LEN_W) ? {irbfs_pkg::LEN_W{1'b1}}
                                      : irbfs_pkg::LEN_W'((64'd1 << PERIOD_BITS) - 64'd1);

  // Configuration registers.
  logic [irbfs_pkg::ID_W-1:0]  beacon_id_r;
  logic [irbfs_pkg::LEN_W-1:0] preamble_on_len_r;
  logic [irbfs_pkg::LEN_W-1:0] preamble_gap_len_r;
  logic [irbfs_pkg::LEN_W-1:0] data_bit_len_r;
  logic [irbfs_pkg::LEN_W-1:0] epilogue_on_len_r;
  logic [irbfs_pkg::LEN_W-1:0] epilogue_gap_len_r;
  logic [irbfs_pkg::LEN_W-1:0] idle_gap_len_r;
  logic                        carrier_direct_r;

  // Frame state.
  logic [irbfs_pkg::PH_W-1:0]  phase_r, phase_nxt;
  logic [1:0]                  word_index_r, word_index_nxt;
  logic [IDX_W-1:0]            bit_index_r, bit_index_nxt;
  logic [irbfs_pkg::ID_W-1:0]  angle_hold_r, angle_hold_nxt;
  logic                        last_level_r, last_level_nxt;
  logic [irbfs_pkg::LEN_W-1:0] last_period_r, last_period_nxt;

  // Result register.
  logic                 out_valid_r;
  irbfs_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_fire;
  logic out_fire;
  logic cfg_fire;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_fire     = out_valid_r && out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // Data bit selection: the word is zero extended to WORD_BITS bits, so only
  // the low eight bit positions can carry a one.
  logic [irbfs_pkg::ID_W-1:0] cur_word;
  logic [IDX_W-1:0]           data_b;
  logic [IDX_W-1:0]           data_sh;
  logic                       data_lvl;

  always_comb begin
    case (word_index_r)
      irbfs_pkg::WORD_ID:    cur_word = beacon_id_r;
      irbfs_pkg::WORD_ANGLE: cur_word = angle_hold_r;
      default:               cur_word = ~angle_hold_r;
    endcase
    data_b   = (bit_index_r >= LAST_BIT) ? LAST_BIT : bit_index_r;
    data_sh  = LAST_BIT - data_b;
    data_lvl = ({1'b0, data_sh} < (IDX_W + 1)'(8)) ? cur_word[data_sh[2:0]] : 1'b0;
  end

  // Next state and result for the request at the input.
  always_comb begin
    logic                        taken;
    logic                        refused;
    logic                        done;
    logic                        lvl;
    logic [irbfs_pkg::LEN_W-1:0] per;

    phase_nxt       = phase_r;
    word_index_nxt  = word_index_r;
    bit_index_nxt   = bit_index_r;
    angle_hold_nxt  = angle_hold_r;
    last_level_nxt  = last_level_r;
    last_period_nxt = last_period_r;
    taken           = 1'b0;
    refused         = 1'b0;
    done            = 1'b0;
    lvl             = 1'b0;
    per             = idle_gap_len_r;

    if (in_if.data.req_type == irbfs_pkg::REQ_START) begin
      if (phase_r == irbfs_pkg::PH_IDLE) begin
        taken          = 1'b1;
        angle_hold_nxt = in_if.data.angle_word;
        phase_nxt      = irbfs_pkg::PH_PRE;
        word_index_nxt = '0;
        bit_index_nxt  = '0;
      end else begin
        refused = 1'b1;
      end
    end else begin
      if (phase_r == irbfs_pkg::PH_IDLE) begin
        lvl = 1'b0;
        per = idle_gap_len_r;
      end else if (phase_r == irbfs_pkg::PH_PRE) begin
        // Even steps are carrier on, odd steps are gaps.
        lvl = !bit_index_r[0];
        per = lvl ? preamble_on_len_r : preamble_gap_len_r;
        if (bit_index_r[1:0] == 2'd3) begin
          phase_nxt      = irbfs_pkg::PH_DATA;
          word_index_nxt = '0;
          bit_index_nxt  = '0;
        end else begin
          bit_index_nxt = IDX_W'(bit_index_r[1:0]) + IDX_W'(1);
        end
      end else if (phase_r == irbfs_pkg::PH_DATA && word_index_r != 2'd3) begin
        lvl = data_lvl;
        per = data_bit_len_r;
        if (data_b == LAST_BIT) begin
          bit_index_nxt = '0;
          if (word_index_r == irbfs_pkg::WORD_COMPL) begin
            word_index_nxt = '0;
            phase_nxt      = irbfs_pkg::PH_EGAP;
          end else begin
            word_index_nxt = word_index_r + 2'd1;
          end
        end else begin
          bit_index_nxt = data_b + IDX_W'(1);
        end
      end else if (phase_r == irbfs_pkg::PH_EGAP) begin
        lvl       = 1'b0;
        per       = epilogue_gap_len_r;
        phase_nxt = irbfs_pkg::PH_EON;
      end else if (phase_r == irbfs_pkg::PH_EON) begin
        lvl       = 1'b1;
        per       = epilogue_on_len_r;
        phase_nxt = irbfs_pkg::PH_END;
      end else begin
        // Normal end of frame; unused phase codes end the frame the same way.
        lvl            = 1'b0;
        per            = idle_gap_len_r;
        done           = 1'b1;
        phase_nxt      = irbfs_pkg::PH_IDLE;
        word_index_nxt = '0;
        bit_index_nxt  = '0;
      end
      last_level_nxt  = lvl;
      last_period_nxt = per & PER_MASK;
    end

    out_data_nxt.carrier_on    = carrier_direct_r ? last_level_nxt : !last_level_nxt;
    out_data_nxt.period_length = last_period_nxt;
    out_data_nxt.start_taken   = taken;
    out_data_nxt.start_refused = refused;
    out_data_nxt.frame_done    = done;
    out_data_nxt.busy_res      = (phase_nxt != irbfs_pkg::PH_IDLE);
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= irbfs_pkg::PH_IDLE;
      word_index_r  <= '0;
      bit_index_r   <= '0;
      angle_hold_r  <= '0;
      last_level_r  <= 1'b0;
      last_period_r <= irbfs_pkg::LEN_W'(1000);
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r       <= phase_nxt;
        word_index_r  <= word_index_nxt;
        bit_index_r   <= bit_index_nxt;
        angle_hold_r  <= angle_hold_nxt;
        last_level_r  <= last_level_nxt;
        last_period_r <= last_period_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beacon_id_r        <= '0;
      preamble_on_len_r  <= irbfs_pkg::LEN_W'(750);
      preamble_gap_len_r <= irbfs_pkg::LEN_W'(350);
      data_bit_len_r     <= irbfs_pkg::LEN_W'(500);
      epilogue_on_len_r  <= irbfs_pkg::LEN_W'(750);
      epilogue_gap_len_r <= irbfs_pkg::LEN_W'(350);
      idle_gap_len_r     <= irbfs_pkg::LEN_W'(1000);
      carrier_direct_r   <= 1'b1;
    end else if (cfg_fire) begin
      unique case (cfg_if.data.index)
        irbfs_pkg::REG_BEACON_ID:
          beacon_id_r <= cfg_if.data.wdata[irbfs_pkg::ID_W-1:0];
        irbfs_pkg::REG_PREAMBLE_ON_LEN:
          preamble_on_len_r <= cfg_if.data.wdata[irbfs_pkg::LEN_W-1:0];
        irbfs_pkg::REG_PREAMBLE_GAP_LEN:
          preamble_gap_len_r <= cfg_if.data.wdata[irbfs_pkg::LEN_W-1:0];
        irbfs_pkg::REG_DATA_BIT_LEN:
          data_bit_len_r <= cfg_if.data.wdata[irbfs_pkg::LEN_W-1:0];
        irbfs_pkg::REG_EPILOGUE_ON_LEN:
          epilogue_on_len_r <= cfg_if.data.wdata[irbfs_pkg::LEN_W-1:0];
        irbfs_pkg::REG_EPILOGUE_GAP_LEN:
          epilogue_gap_len_r <= cfg_if.data.wdata[irbfs_pkg::LEN_W-1:0];
        irbfs_pkg::REG_IDLE_GAP_LEN:
          idle_gap_len_r <= cfg_if.data.wdata[irbfs_pkg::LEN_W-1:0];
        irbfs_pkg::REG_CARRIER_DIRECT:
          carrier_direct_r <= cfg_if.data.wdata[0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ bench/tb_ir_beacon_frame_sequencer_top.sv @@
// Self-checking testbench for the IR beacon frame sequencer: random frames against a predictor.
`timescale 1ns / 1ps

// The bench pushes requests into a queue from the main initial block. A
// driver on the falling edge presents them on the request channel, and a
// capture process on the rising edge runs each accepted request through a
// local frame predictor, which yields the expected result. A monitor on the
// rising edge compares every accepted result with the oldest expected one.
// Register writes are made only when no request is queued and no result is
// owed, so the predictor's copy of the registers always matches the block's.
module tb_ir_beacon_frame_sequencer_top;
  import irbfs_pkg::*;

  localparam int WORD_BITS   = 8;
  localparam int PERIOD_BITS = 16;

  // Each side drops its valid or ready in about this many cycles of a hundred.
  localparam int IDLE_PCT     = 8;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Cap on printed mismatch lines; all mismatches are still counted.
  localparam int MAX_REPORTS  = 40;
  // Settling time after the last result; the block's result is registered.
  localparam int DRAIN_CYCLES = 8;
  // Ticks in one whole frame: four preamble steps, three words, the two
  // epilogue steps and the tick that returns to idle.
  localparam int FRAME_TICKS  = 4 + 3 * WORD_BITS + 3;
  // An index outside the register map; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;

  logic clk;
  logic rst_n;

  irbfs_stream_if #(.T(in_item_t))  in_ch  ();
  irbfs_stream_if #(.T(out_item_t)) out_ch ();
  irbfs_stream_if #(.T(cfg_req_t))  cfg_ch ();

  ir_beacon_frame_sequencer_top #(
    .WORD_BITS  (WORD_BITS),
    .PERIOD_BITS(PERIOD_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // Requests waiting to be presented, and results the block still owes.
  in_item_t  req_queue[$];
  out_item_t results_due[$];

  // Set while one long stretch of the run is played without any idling.
  logic quiet;
  // High for the cycle after a request was taken, so the driver moves on.
  logic in_fire;
  int   mismatches;
  int   stall_cycles;

  // Predictor copy of the registers.
  logic [ID_W-1:0]  bcn_beacon_id;
  logic [LEN_W-1:0] bcn_pre_on;
  logic [LEN_W-1:0] bcn_pre_gap;
  logic [LEN_W-1:0] bcn_bit_len;
  logic [LEN_W-1:0] bcn_epi_on;
  logic [LEN_W-1:0] bcn_epi_gap;
  logic [LEN_W-1:0] bcn_idle_gap;
  logic             bcn_direct;

  // Predictor copy of the frame state.
  logic [PH_W-1:0]  bcn_phase;
  logic [1:0]       bcn_word;
  logic [2:0]       bcn_bit;
  logic [ID_W-1:0]  bcn_angle;
  logic             bcn_level;
  logic [LEN_W-1:0] bcn_period;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the predicted frame by one request and returns the result that
  // the block must give for it. Start requests leave the level and period
  // as they were; only ticks move the frame along.
  function automatic out_item_t beacon_advance(in_item_t rq);
    out_item_t        r;
    logic             lvl;
    logic [LEN_W-1:0] per;
    logic [ID_W-1:0]  word;
    r = '0;
    if (rq.req_type == REQ_START) begin
      if (bcn_phase == PH_IDLE) begin
        r.start_taken = 1'b1;
        bcn_angle     = rq.angle_word;
        bcn_phase     = PH_PRE;
        bcn_word      = WORD_ID;
        bcn_bit       = '0;
      end else begin
        r.start_refused = 1'b1;
      end
    end else begin
      lvl = 1'b0;
      per = bcn_idle_gap;
      case (bcn_phase)
        PH_IDLE: begin
          lvl = 1'b0;
        end
        PH_PRE: begin
          // Even steps carry the carrier, odd steps are gaps.
          lvl = ~bcn_bit[0];
          per = lvl ? bcn_pre_on : bcn_pre_gap;
          if (bcn_bit[1:0] == 2'd3) begin
            bcn_phase = PH_DATA;
            bcn_word  = WORD_ID;
            bcn_bit   = '0;
          end else begin
            bcn_bit = bcn_bit + 3'd1;
          end
        end
        PH_DATA: begin
          case (bcn_word)
            WORD_ID:    word = bcn_beacon_id;
            WORD_ANGLE: word = bcn_angle;
            default:    word = ~bcn_angle;
          endcase
          lvl = word[WORD_BITS - 1 - bcn_bit];
          per = bcn_bit_len;
          if (bcn_bit == WORD_BITS - 1) begin
            bcn_bit = '0;
            if (bcn_word == WORD_COMPL) begin
              bcn_word  = WORD_ID;
              bcn_phase = PH_EGAP;
            end else begin
              bcn_word = bcn_word + 2'd1;
            end
          end else begin
            bcn_bit = bcn_bit + 3'd1;
          end
        end
        PH_EGAP: begin
          lvl       = 1'b0;
          per       = bcn_epi_gap;
          bcn_phase = PH_EON;
        end
        PH_EON: begin
          lvl       = 1'b1;
          per       = bcn_epi_on;
          bcn_phase = PH_END;
        end
        default: begin
          // End of frame, and the way out of any phase code not in use.
          lvl          = 1'b0;
          per          = bcn_idle_gap;
          r.frame_done = 1'b1;
          bcn_phase    = PH_IDLE;
          bcn_word     = WORD_ID;
          bcn_bit      = '0;
        end
      endcase
      bcn_level  = lvl;
      bcn_period = per;
    end
    r.carrier_on    = bcn_direct ? bcn_level : ~bcn_level;
    r.period_length = bcn_period;
    r.busy_res      = (bcn_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void push_req(logic kind, logic [ID_W-1:0] angle);
    in_item_t it;
    it.req_type   = kind;
    it.angle_word = angle;
    req_queue.push_back(it);
  endfunction

  // Mostly short lengths so frames stay quick, now and then the full range.
  function automatic logic [LEN_W-1:0] pick_len();
    if ($urandom_range(0, 3) == 0) return LEN_W'($urandom_range(1, 65535));
    return LEN_W'($urandom_range(1, 64));
  endfunction

  // Capture: register writes and accepted requests update the predictor on
  // the same edge at which the block takes them.
  always @(posedge clk) begin
    if (!rst_n) begin
      bcn_beacon_id <= '0;
      bcn_pre_on    <= 16'd750;
      bcn_pre_gap   <= 16'd350;
      bcn_bit_len   <= 16'd500;
      bcn_epi_on    <= 16'd750;
      bcn_epi_gap   <= 16'd350;
      bcn_idle_gap  <= 16'd1000;
      bcn_direct    <= 1'b1;
      bcn_phase     <= PH_IDLE;
      bcn_word      <= WORD_ID;
      bcn_bit       <= '0;
      bcn_angle     <= '0;
      bcn_level     <= 1'b0;
      bcn_period    <= 16'd1000;
      in_fire       <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_BEACON_ID:        bcn_beacon_id <= cfg_ch.data.wdata[ID_W-1:0];
          REG_PREAMBLE_ON_LEN:  bcn_pre_on    <= cfg_ch.data.wdata;
          REG_PREAMBLE_GAP_LEN: bcn_pre_gap   <= cfg_ch.data.wdata;
          REG_DATA_BIT_LEN:     bcn_bit_len   <= cfg_ch.data.wdata;
          REG_EPILOGUE_ON_LEN:  bcn_epi_on    <= cfg_ch.data.wdata;
          REG_EPILOGUE_GAP_LEN: bcn_epi_gap   <= cfg_ch.data.wdata;
          REG_IDLE_GAP_LEN:     bcn_idle_gap  <= cfg_ch.data.wdata;
          REG_CARRIER_DIRECT:   bcn_direct    <= cfg_ch.data.wdata[0];
          default: ;
        endcase
      end
      // The predictor state is written with blocking assignments inside the
      // function; writes never share an edge with requests, so the two
      // kinds of update cannot collide.
      if (in_ch.valid && in_ch.ready) begin
        results_due.push_back(beacon_advance(in_ch.data));
        req_queue.delete(0);
      end
      in_fire <= in_ch.valid && in_ch.ready;
    end
  end

  // Driver: a request that is shown stays until it is taken; after that the
  // next one from the queue goes out unless this cycle is an idle one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (req_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= req_queue[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // The result side stalls at random as well.
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic check_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Monitor: every result taken is matched against the oldest expectation.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result expected none, got %p", $time, out_ch.data);
      end else begin
        want = results_due.pop_front();
        check_field("carrier_on", LEN_W'(want.carrier_on),
                    LEN_W'(out_ch.data.carrier_on));
        check_field("period_length", want.period_length, out_ch.data.period_length);
        check_field("start_taken", LEN_W'(want.start_taken),
                    LEN_W'(out_ch.data.start_taken));
        check_field("start_refused", LEN_W'(want.start_refused),
                    LEN_W'(out_ch.data.start_refused));
        check_field("frame_done", LEN_W'(want.frame_done),
                    LEN_W'(out_ch.data.frame_done));
        check_field("busy_res", LEN_W'(want.busy_res),
                    LEN_W'(out_ch.data.busy_res));
      end
    end
  end

  // Watchdog: the run is hung when no channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("tb_ir_beacon_frame_sequencer_top: done, errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the write is
  // taken, with valid still high so that back-to-back writes need no gap.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the whole register map. The narrow registers get random upper
  // bits, which the block must drop.
  task automatic load_setting(logic [ID_W-1:0] id, logic [LEN_W-1:0] pon,
                              logic [LEN_W-1:0] pgap, logic [LEN_W-1:0] dbit,
                              logic [LEN_W-1:0] eon, logic [LEN_W-1:0] egap,
                              logic [LEN_W-1:0] igap, logic dir);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_BEACON_ID,        {junk[15:8], id});
    write_reg(REG_PREAMBLE_ON_LEN,  pon);
    write_reg(REG_PREAMBLE_GAP_LEN, pgap);
    write_reg(REG_DATA_BIT_LEN,     dbit);
    write_reg(REG_EPILOGUE_ON_LEN,  eon);
    write_reg(REG_EPILOGUE_GAP_LEN, egap);
    write_reg(REG_IDLE_GAP_LEN,     igap);
    write_reg(REG_CARRIER_DIRECT,   {junk[15:1], dir});
    cfg_ch.valid <= 1'b0;
  endtask

  // Returns at a falling edge once nothing is queued and nothing is owed.
  task automatic wait_drain();
    do @(negedge clk); while (req_queue.size() != 0 || results_due.size() != 0);
  endtask

  // Most traffic is whole frames: a start, then exactly enough ticks to run
  // the frame back to idle, with an occasional refused start mixed in and a
  // few idle ticks after. The rest is short bursts of random requests, which
  // can leave a frame half done and push the next start into the busy case.
  task automatic queue_traffic(int n);
    int added;
    int burst;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 99) < 80) begin
        push_req(REQ_START, ID_W'($urandom_range(0, 255)));
        added++;
        for (int k = 0; k < FRAME_TICKS; k++) begin
          if ($urandom_range(0, 99) < 5) begin
            push_req(REQ_START, ID_W'($urandom_range(0, 255)));
            added++;
          end
          push_req(REQ_TICK, ID_W'($urandom_range(0, 255)));
          added++;
        end
        burst = $urandom_range(0, 3);
        repeat (burst) push_req(REQ_TICK, ID_W'($urandom_range(0, 255)));
        added += burst;
      end else begin
        burst = $urandom_range(1, 8);
        repeat (burst) push_req(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 255)));
        added += burst;
      end
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    quiet        = 1'b0;
    mismatches   = 0;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset register values: a tick while idle, a start
    // with the lowest angle code, a start while busy with the highest one,
    // then the whole frame and one more idle tick.
    push_req(REQ_TICK, 8'h00);
    push_req(REQ_START, 8'h00);
    push_req(REQ_START, 8'hFF);
    repeat (FRAME_TICKS) push_req(REQ_TICK, 8'hFF);
    push_req(REQ_TICK, 8'h00);
    wait_drain();

    // Random phases, each with its own register setting: all maximum with
    // inverted polarity, all lengths one, zero lengths, then random settings.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 5) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
      case (ph)
        0: load_setting(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 1'b0);
        1: load_setting(8'h00, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
        2: load_setting(ID_W'($urandom_range(0, 255)), '0, '0, '0, '0, '0, '0, 1'b0);
        default: load_setting(ID_W'($urandom_range(0, 255)), pick_len(), pick_len(),
                              pick_len(), pick_len(), pick_len(), pick_len(),
                              1'($urandom_range(0, 1)));
      endcase
      // One phase runs with both sides always willing.
      quiet = (ph == 3);
      queue_traffic(105);
      // In one phase the sender holds off halfway until the block is empty.
      if (ph == 4) wait_drain();
      queue_traffic(105);
      wait_drain();
    end
    quiet = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      mismatches += results_due.size();
      $display("%0t: %0d expected results, got none", $time, results_due.size());
    end
    if (mismatches == 0) begin
      $display("tb_ir_beacon_frame_sequencer_top: done, clean");
    end else begin
      $display("tb_ir_beacon_frame_sequencer_top: done, errors");
    end
    $finish;
  end

endmodule
